@@ sv/crat_pkg.sv @@
package crat_pkg;

  localparam int WORD_W              = 32;
  localparam int PROD_W              = 2 * WORD_W;
  localparam int CFG_W               = 5;
  localparam int ROM_IDX_W           = 5;
  localparam int ROM_FRAC            = 30;
  localparam int ANGLE_BITS_DEF      = 32;
  localparam int TABLE_FRAC_BITS_DEF = 30;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(30);

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // take a new angle, vector to 1.0
    logic mul;       // capture the four partial products
    logic upd;       // combine products into the new vector
    logic step;      // advance to the next angle bit
    logic out_load;  // capture the scaled result
  } crat_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bit_set;
    logic scan_done;
  } crat_sts_t;

  // rotation table, Q30, real part
  function automatic word_t rom_re(input logic [ROM_IDX_W-1:0] idx);
    word_t v;
    unique case (idx)
      5'd0:  v = 32'shc0000000;
      5'd1:  v = 32'sh00000000;
      5'd2:  v = 32'sh2d413ccd;
      5'd3:  v = 32'sh3b20d79e;
      5'd4:  v = 32'sh3ec52fa0;
      5'd5:  v = 32'sh3fb11b48;
      5'd6:  v = 32'sh3fec43c7;
      5'd7:  v = 32'sh3ffb10c1;
      5'd8:  v = 32'sh3ffec42d;
      5'd9:  v = 32'sh3fffb10b;
      5'd10: v = 32'sh3fffec43;
      5'd11: v = 32'sh3ffffb11;
      5'd12: v = 32'sh3ffffec4;
      5'd13: v = 32'sh3fffffb1;
      5'd14: v = 32'sh3fffffec;
      5'd15: v = 32'sh3ffffffb;
      5'd16: v = 32'sh3fffffff;
      default: v = 32'sh40000000;
    endcase
    return v;
  endfunction

  // rotation table, Q30, imaginary part
  function automatic word_t rom_im(input logic [ROM_IDX_W-1:0] idx);
    word_t v;
    unique case (idx)
      5'd0:  v = 32'sh00000000;
      5'd1:  v = 32'sh40000000;
      5'd2:  v = 32'sh2d413ccd;
      5'd3:  v = 32'sh187de2a7;
      5'd4:  v = 32'sh0c7c5c1e;
      5'd5:  v = 32'sh0645e9af;
      5'd6:  v = 32'sh0323ecbe;
      5'd7:  v = 32'sh0192155f;
      5'd8:  v = 32'sh00c90e90;
      5'd9:  v = 32'sh006487c4;
      5'd10: v = 32'sh003243f1;
      5'd11: v = 32'sh001921fb;
      5'd12: v = 32'sh000c90fe;
      5'd13: v = 32'sh0006487f;
      5'd14: v = 32'sh0003243f;
      5'd15: v = 32'sh00019220;
      5'd16: v = 32'sh0000c910;
      5'd17: v = 32'sh00006488;
      5'd18: v = 32'sh00003244;
      5'd19: v = 32'sh00001922;
      5'd20: v = 32'sh00000c91;
      5'd21: v = 32'sh00000648;
      5'd22: v = 32'sh00000324;
      5'd23: v = 32'sh00000192;
      5'd24: v = 32'sh000000c9;
      5'd25: v = 32'sh00000065;
      5'd26: v = 32'sh00000032;
      5'd27: v = 32'sh00000019;
      5'd28: v = 32'sh0000000d;
      5'd29: v = 32'sh00000006;
      5'd30: v = 32'sh00000003;
      5'd31: v = 32'sh00000001;
      default: v = 32'sh00000000;
    endcase
    return v;
  endfunction

endpackage

@@ sv/crat_ctrl.sv @@
module crat_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  crat_pkg::crat_sts_t sts,
  output crat_pkg::crat_cmd_t cmd
);
  import crat_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_DONE;
        end else if (sts.bit_set) begin
          cmd.mul   = 1'b1;
          state_nxt = S_UPD;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        cmd.step  = 1'b1;
        state_nxt = S_SCAN;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ sv/crat_dp.sv @@
module crat_dp #(
  parameter int ANGLE_BITS      = crat_pkg::ANGLE_BITS_DEF,
  parameter int TABLE_FRAC_BITS = crat_pkg::TABLE_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [crat_pkg::WORD_W-1:0]   in_angle,
  input  logic                          cfg_we,
  input  logic [crat_pkg::CFG_W-1:0]    cfg_wdata,
  input  crat_pkg::crat_cmd_t           cmd,
  output crat_pkg::crat_sts_t           sts,
  output logic signed [crat_pkg::WORD_W-1:0] out_cos_part,
  output logic signed [crat_pkg::WORD_W-1:0] out_sin_part
);
  import crat_pkg::*;

  localparam int CNT_W = $clog2(ANGLE_BITS + 1);
  localparam int TSH   = ROM_FRAC - TABLE_FRAC_BITS;
  localparam logic [CFG_W-1:0] TFB_C = CFG_W'(TABLE_FRAC_BITS);
  localparam word_t ONE = word_t'(64'sd1 <<< TABLE_FRAC_BITS);

  logic [CFG_W-1:0]      cfg_r;
  logic [ANGLE_BITS-1:0] ang_r;
  logic [CNT_W-1:0]      cnt_r;
  word_t                 vx_r, vy_r;
  prod_t                 pxx_r, pyy_r, pxy_r, pyx_r;
  word_t                 cos_r, sin_r;

  logic [ROM_IDX_W-1:0]  idx;
  word_t                 tx, ty;
  prod_t                 nx, ny;
  logic [CFG_W-1:0]      f, sh;
  word_t                 cos_nxt, sin_nxt;

  assign idx = ROM_IDX_W'(cnt_r);
  assign tx  = rom_re(idx) >>> TSH;
  assign ty  = rom_im(idx) >>> TSH;

  assign sts.bit_set   = ang_r[ANGLE_BITS-1];
  assign sts.scan_done = (cnt_r == CNT_W'(ANGLE_BITS));

  assign nx = pxx_r - pyy_r;
  assign ny = pxy_r + pyx_r;

  // final rescale to the configured fraction width
  always_comb begin
    f = (cfg_r > CFG_W'(ROM_FRAC)) ? CFG_W'(ROM_FRAC) : cfg_r;
    if (f <= TFB_C) begin
      sh      = TFB_C - f;
      cos_nxt = vx_r >>> sh;
      sin_nxt = vy_r >>> sh;
    end else begin
      sh      = f - TFB_C;
      cos_nxt = vx_r <<< sh;
      sin_nxt = vy_r <<< sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ang_r <= in_angle[WORD_W-1 -: ANGLE_BITS];
      cnt_r <= '0;
      vx_r  <= ONE;
      vy_r  <= '0;
    end else begin
      if (cmd.step) begin
        ang_r <= ang_r << 1;
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.upd) begin
        vx_r <= nx[TABLE_FRAC_BITS +: WORD_W];
        vy_r <= ny[TABLE_FRAC_BITS +: WORD_W];
      end
    end
    if (cmd.mul) begin
      pxx_r <= vx_r * tx;
      pyy_r <= vy_r * ty;
      pxy_r <= vx_r * ty;
      pyx_r <= vy_r * tx;
    end
    if (cmd.out_load) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign out_cos_part = cos_r;
  assign out_sin_part = sin_r;

endmodule

@@ sv/complex_rotate_by_angle_table.sv @@
// angle to unit vector: in_angle is an unsigned fraction of a full turn
// (2^32 = 360 degrees); the result is (cos, sin) as signed fixed point with
// cfg_out_frac_bits fraction bits (reset 30, values above 30 act as 30).
// the vector starts at 1.0 and is rotated by one table constant for each set
// bit among the top ANGLE_BITS angle bits, msb first. one transaction in,
// one transaction out. after an input transaction the block examines the
// top ANGLE_BITS angle bits one by one, msb first; each set bit adds a
// vector update step, since the complex multiply registers its four partial
// products and combines them in the next cycle. the scaled result is
// registered once the output register is free. the output register holds
// a finished result while the next angle is processed.
// write cfg_out_frac_bits only while idle.
module complex_rotate_by_angle_table #(
  parameter int ANGLE_BITS      = crat_pkg::ANGLE_BITS_DEF,
  parameter int TABLE_FRAC_BITS = crat_pkg::TABLE_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [crat_pkg::WORD_W-1:0]        in_angle,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [crat_pkg::WORD_W-1:0] out_cos_part,
  output logic signed [crat_pkg::WORD_W-1:0] out_sin_part,
  // configuration
  input  logic                               cfg_we,
  input  logic [crat_pkg::CFG_W-1:0]         cfg_wdata
);
  import crat_pkg::*;

  crat_cmd_t cmd;
  crat_sts_t sts;

  // fsm: idle, bit scan, vector update, result hand-off
  crat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // vector registers, rotation table, four multipliers, output scaler
  crat_dp #(
    .ANGLE_BITS      (ANGLE_BITS),
    .TABLE_FRAC_BITS (TABLE_FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_angle     (in_angle),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .sts          (sts),
    .out_cos_part (out_cos_part),
    .out_sin_part (out_sin_part)
  );

  // an accepted transaction keeps the input closed while it is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after accepting a transaction");

  // the vector update always follows a product capture
  a_upd_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> $past(cmd.mul))
    else $error("vector update without captured products");

  // a new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result register overwritten while stalled");

  // results only appear after a finished scan
  a_out_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.scan_done)
    else $error("result loaded before all angle bits were examined");

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import crat_pkg::*;

  // run limits and traffic shaping
  localparam int RUN_LIMIT   = 1000000;  // far above the slowest legal run
  localparam int HOLD_CYCLES = 300;      // long receiver hold-off for the pressure test
  localparam int IDLE_PCT    = 31;       // chance of an idle cycle on either side
  localparam int TAIL_CYCLES = 80;       // covers the longest result latency, plus margin
  localparam int PHASE_ITEMS = 100;

  // our own copy of the rotation table, Q30, one (re, im) pair per angle bit
  localparam logic [31:0] TURN_RE [32] = '{
    32'hc0000000, 32'h00000000, 32'h2d413ccd, 32'h3b20d79e,
    32'h3ec52fa0, 32'h3fb11b48, 32'h3fec43c7, 32'h3ffb10c1,
    32'h3ffec42d, 32'h3fffb10b, 32'h3fffec43, 32'h3ffffb11,
    32'h3ffffec4, 32'h3fffffb1, 32'h3fffffec, 32'h3ffffffb,
    32'h3fffffff, 32'h40000000, 32'h40000000, 32'h40000000,
    32'h40000000, 32'h40000000, 32'h40000000, 32'h40000000,
    32'h40000000, 32'h40000000, 32'h40000000, 32'h40000000,
    32'h40000000, 32'h40000000, 32'h40000000, 32'h40000000
  };
  localparam logic [31:0] TURN_IM [32] = '{
    32'h00000000, 32'h40000000, 32'h2d413ccd, 32'h187de2a7,
    32'h0c7c5c1e, 32'h0645e9af, 32'h0323ecbe, 32'h0192155f,
    32'h00c90e90, 32'h006487c4, 32'h003243f1, 32'h001921fb,
    32'h000c90fe, 32'h0006487f, 32'h0003243f, 32'h00019220,
    32'h0000c910, 32'h00006488, 32'h00003244, 32'h00001922,
    32'h00000c91, 32'h00000648, 32'h00000324, 32'h00000192,
    32'h000000c9, 32'h00000065, 32'h00000032, 32'h00000019,
    32'h0000000d, 32'h00000006, 32'h00000003, 32'h00000001
  };

  typedef logic signed [63:0] wide_t;

  // one expected unit vector, tagged with the angle that produced it
  typedef struct {
    logic [31:0] angle;
    word_t       cos_v;
    word_t       sin_v;
  } unit_vec_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [WORD_W-1:0] in_angle = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  word_t             out_cos_part;
  word_t             out_sin_part;
  logic              cfg_we = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  unit_vec_t        pending_vectors[$];
  logic [CFG_W-1:0] frac_setting = CFG_RESET;  // testbench copy of the register
  bit               calm = 1'b0;               // no idling on either side while set
  int               hold_asked = 0;            // bumped by a test to ask for a hold-off
  int               hold_seen = 0;
  int               hold_left = 0;
  int               mismatches = 0;
  int               results_checked = 0;
  int               angles_sent = 0;
  int               cycle_count = 0;

  complex_rotate_by_angle_table dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_angle         (in_angle),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cos_part     (out_cos_part),
    .out_sin_part     (out_sin_part),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // expected unit vector for one angle: start at 1.0 in q30, rotate by the
  // table pair of every set bit msb first, truncate each product by >>> 30
  // and wrap to 32 bits, then rescale to the output fraction width
  function automatic void rotate_to_vector(input logic [31:0] ang,
                                           input logic [CFG_W-1:0] frac,
                                           output word_t cos_v,
                                           output word_t sin_v);
    wide_t vx, vy, tx, ty, nx, ny;
    int    f;
    vx = wide_t'(1) <<< 30;
    vy = '0;
    for (int i = 0; i < 32; i++) begin
      if (ang[31-i]) begin
        tx = wide_t'($signed(TURN_RE[i]));
        ty = wide_t'($signed(TURN_IM[i]));
        nx = (vx * tx - vy * ty) >>> 30;
        ny = (vx * ty + vy * tx) >>> 30;
        vx = wide_t'($signed(nx[31:0]));
        vy = wide_t'($signed(ny[31:0]));
      end
    end
    // a setting of 31 acts as 30
    f = (frac > 30) ? 30 : int'(frac);
    vx = vx >>> (30 - f);
    vy = vy >>> (30 - f);
    cos_v = word_t'(vx[31:0]);
    sin_v = word_t'(vy[31:0]);
  endfunction

  // random angle mix: mostly uniform, plus sparse and dense bit patterns
  // (shortest and longest scans) and coarse angles with empty low bits
  function automatic logic [31:0] pick_angle();
    logic [31:0] a;
    case ($urandom_range(0, 9)) inside
      [6:7]: begin
        a = '0;
        repeat ($urandom_range(1, 4)) a[$urandom_range(0, 31)] = 1'b1;
      end
      8: begin
        a = '1;
        repeat ($urandom_range(1, 4)) a[$urandom_range(0, 31)] = 1'b0;
      end
      9: a = $urandom() & 32'hffc00000;
      default: a = $urandom();
    endcase
    return a;
  endfunction

  // offer one angle and hold it until the block takes it; valid stays up on
  // return so back-to-back transactions have no bubble
  task automatic send_angle(input logic [31:0] ang);
    bit        taken;
    unit_vec_t e;
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_angle <= ang;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
      @(negedge clk);
    end
    e.angle = ang;
    rotate_to_vector(ang, frac_setting, e.cos_v, e.sin_v);
    pending_vectors.push_back(e);
    angles_sent++;
  endtask

  // drop valid and wait until every expected vector has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_vectors.size() != 0) @(negedge clk);
  endtask

  // register writes only happen with the block idle
  task automatic write_out_frac(input logic [CFG_W-1:0] v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    frac_setting = v;
  endtask

  // --- tests ---

  // quadrant corners, single bits, all ones, alternating patterns, at the
  // reset fraction width
  task automatic test_directed_angles();
    logic [31:0] corner_angles [14] = '{
      32'h00000000, 32'hffffffff, 32'h80000000, 32'h40000000,
      32'hc0000000, 32'h20000000, 32'h00000001, 32'h7fffffff,
      32'h55555555, 32'haaaaaaaa, 32'h60000000, 32'h00010000,
      32'h80000001, 32'h0000ffff
    };
    foreach (corner_angles[i]) send_angle(corner_angles[i]);
  endtask

  // out_frac_bits extremes: 31 acts as 30, 0 leaves only the sign and the
  // integer part, 1 keeps one fraction bit
  task automatic test_frac_extremes();
    logic [CFG_W-1:0] frac_plan [4] = '{5'd31, 5'd0, 5'd1, 5'd30};
    foreach (frac_plan[i]) begin
      write_out_frac(frac_plan[i]);
      send_angle(32'h2aaaaaab);
      send_angle(32'hffffffff);
    end
  endtask

  // receiver holds off for a long stretch while the sender keeps offering,
  // so the output register fills and the block stalls its input
  task automatic test_output_backpressure();
    calm = 1'b1;
    hold_asked++;
    repeat (20) send_angle(pick_angle());
    calm = 1'b0;
  endtask

  // sender pauses mid-stream until every result is back, then resumes
  task automatic test_sender_pause();
    repeat (5) send_angle(pick_angle());
    drain_results();
    repeat (5) send_angle(pick_angle());
  endtask

  // random angles over several fraction widths; one phase with no idling
  task automatic test_random_angles();
    logic [CFG_W-1:0] frac;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: frac = 5'd30;
        1: frac = 5'd0;
        2: frac = 5'd31;
        3: frac = 5'd16;
        default: frac = CFG_W'($urandom_range(0, 31));
      endcase
      write_out_frac(frac);
      calm = (ph == 3);
      repeat (PHASE_ITEMS) send_angle(pick_angle());
    end
    calm = 1'b0;
  endtask

  // receiver side: random stall, or a long hold-off when a test asks
  always @(negedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    unit_vec_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_vectors.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, cos %h sin %h",
                 $time, out_cos_part, out_sin_part);
      end else begin
        e = pending_vectors.pop_front();
        results_checked++;
        if (out_cos_part !== e.cos_v) begin
          mismatches++;
          $display("%0t: angle %h cos_part expected %h actual %h",
                   $time, e.angle, e.cos_v, out_cos_part);
        end
        if (out_sin_part !== e.sin_v) begin
          mismatches++;
          $display("%0t: angle %h sin_part expected %h actual %h",
                   $time, e.angle, e.sin_v, out_sin_part);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_vectors.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_angles();
    test_frac_extremes();
    test_output_backpressure();
    test_sender_pause();
    test_random_angles();

    // let any stray result show up before the verdict
    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d angles and %0d results over fraction widths 0 to 31,",
             angles_sent, results_checked);
    $display("with random idling, a long output hold-off and a sender pause");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/crat_pkg.sv
sv/crat_ctrl.sv
sv/crat_dp.sv
sv/complex_rotate_by_angle_table.sv
tb/tb_top.sv
